### design/weighted_graph_adjacency_store_top_macros.svh
// Assertion macros shared by the weighted graph adjacency store RTL.
`ifndef WEIGHTED_GRAPH_ADJACENCY_STORE_TOP_MACROS_SVH
`define WEIGHTED_GRAPH_ADJACENCY_STORE_TOP_MACROS_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define WGAS_ASSERT_HOLD(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define WGAS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

### design/wgas_pkg.sv
// Package with the types, constants and codes of the weighted graph adjacency store.
`timescale 1ns / 1ps
package wgas_pkg;

	localparam int MAX_VERTICES = 16;
	localparam int NAME_BYTES   = 8;

	localparam int NAME_W   = 64;
	localparam int WEIGHT_W = 16;
	localparam int LIMIT_W  = 5;
	localparam int APB_AW   = 3;
	localparam int APB_DW   = 32;

	localparam int IDX_W     = $clog2(MAX_VERTICES);
	localparam int VCNT_W    = $clog2(MAX_VERTICES + 1);
	localparam int MAT_DEPTH = MAX_VERTICES * MAX_VERTICES;
	localparam int MAT_AW    = $clog2(MAT_DEPTH);
	localparam int LIMCMP_W  = (VCNT_W > LIMIT_W) ? VCNT_W : LIMIT_W;

	// A shift by the full word width yields zero, so eight bytes give all ones.
	localparam logic [NAME_W-1:0] NAME_MASK = (64'd1 << (8 * NAME_BYTES)) - 64'd1;
	localparam logic [LIMCMP_W-1:0] MAX_LIMIT = LIMCMP_W'(MAX_VERTICES);
	localparam logic [LIMIT_W-1:0] VERTEX_LIMIT_RESET = LIMIT_W'(16);

	typedef enum logic [2:0] {
		KIND_ADD_VERTEX  = 3'd0,
		KIND_ADD_EDGE    = 3'd1,
		KIND_READ_WEIGHT = 3'd2,
		KIND_DEGREE      = 3'd3,
		KIND_REMOVE_EDGE = 3'd4
	} kind_t;

	typedef enum logic [2:0] {
		STAT_OK          = 3'd0,
		STAT_FULL        = 3'd1,
		STAT_DUP         = 3'd2,
		STAT_NOT_FOUND   = 3'd3,
		STAT_SELF_LOOP   = 3'd4,
		STAT_NULL_WEIGHT = 3'd5,
		STAT_NO_EDGE     = 3'd6
	} status_t;

	typedef enum logic {
		REG_VERTEX_LIMIT = 1'b0,
		REG_NULL_WEIGHT  = 1'b1
	} reg_idx_t;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_FIND_A,
		S_FIND_B,
		S_WR_AB,
		S_WR_BA,
		S_RD_ADDR,
		S_RD_DATA,
		S_DEGREE
	} state_t;

	typedef struct packed {
		kind_t                      kind;
		logic [NAME_W-1:0]          first_name;
		logic [NAME_W-1:0]          second_name;
		logic signed [WEIGHT_W-1:0] edge_weight;
	} req_t;

	typedef struct packed {
		status_t                    status;
		logic signed [WEIGHT_W-1:0] value;
	} rsp_t;

	typedef struct packed {
		logic [LIMIT_W-1:0]         vertex_limit;
		logic signed [WEIGHT_W-1:0] null_weight;
		logic                       refill;
	} cfg_t;

	typedef struct packed {
		logic              we;
		logic [IDX_W-1:0]  addr;
		logic [NAME_W-1:0] data;
	} name_wr_t;

	typedef struct packed {
		logic                       we;
		logic [MAT_AW-1:0]          addr;
		logic signed [WEIGHT_W-1:0] data;
	} mat_wr_t;

endpackage

### design/weighted_graph_adjacency_store_top.sv
// Top level of the weighted graph adjacency store: configuration port and block wiring.
`timescale 1ns / 1ps
// Undirected weighted graph held as a name table plus a symmetric weight matrix.
// Requests come in on req and are taken at a rising edge where start is high and
// busy is low. Each request not cut short by a null_weight write produces exactly
// one result beat on rsp, marked by a one-cycle done strobe; the receiver cannot
// hold it off, so it must take it then. A request walks the name table one entry
// per cycle through a single registered read port and one shared comparator: a
// name search scans the registered vertices until the name matches, a degree
// count scans the vertex's matrix row, an edge write then writes both mirror
// entries, and an edge read sets the matrix address and then takes the data.
// The strobe follows next cycle; busy drops in the strobe cycle, one item at a time.
// Unknown request kinds answer ok with a zero value in the cycle after accept.
// The APB port sets vertex_limit (offset 0) and null_weight (offset 4). Writing
// null_weight empties the whole matrix to the new value, one matrix entry per
// cycle; busy is high from the cycle after the write until the pass ends.
// Reset clears the vertex count and the registers (limit 16, null weight zero)
// and then runs a clearing pass over the whole matrix before the first request.
module weighted_graph_adjacency_store_top
	import wgas_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	output logic              busy,
	input  req_t              req,
	output logic              done,
	output rsp_t              rsp,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [APB_AW-1:0] paddr,
	input  logic [APB_DW-1:0] pwdata,
	output logic [APB_DW-1:0] prdata,
	output logic              pready
);

	logic [LIMIT_W-1:0]         vertex_limit_q;
	logic signed [WEIGHT_W-1:0] null_weight_q;
	logic                       refill_q;
	logic                       cfg_wr;
	reg_idx_t                   reg_idx;
	cfg_t                       cfg;

	name_wr_t                   nwr;
	logic [IDX_W-1:0]           n_raddr;
	logic [NAME_W-1:0]          n_rdata;
	mat_wr_t                    mwr;
	logic [MAT_AW-1:0]          m_raddr;
	logic signed [WEIGHT_W-1:0] m_rdata;

	// The port never waits; a write lands on the access cycle.
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[2]);

	// A null weight write is held as a one-cycle refill request so that the
	// sequencer sweeps the matrix with the value already in the register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vertex_limit_q <= VERTEX_LIMIT_RESET;
			null_weight_q  <= '0;
			refill_q       <= 1'b0;
		end else begin
			refill_q <= 1'b0;
			if (cfg_wr) begin
				unique case (reg_idx)
					REG_VERTEX_LIMIT: vertex_limit_q <= pwdata[LIMIT_W-1:0];
					REG_NULL_WEIGHT: begin
						null_weight_q <= pwdata[WEIGHT_W-1:0];
						refill_q      <= 1'b1;
					end
					default:          refill_q <= 1'b0;
				endcase
			end
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_VERTEX_LIMIT: prdata = APB_DW'(vertex_limit_q);
			REG_NULL_WEIGHT:  prdata = {{(APB_DW - WEIGHT_W){null_weight_q[WEIGHT_W-1]}},
			                            null_weight_q};
			default:          prdata = '0;
		endcase
	end

	assign cfg = '{vertex_limit: vertex_limit_q, null_weight: null_weight_q, refill: refill_q};

	wgas_name_mem u_names (
		.clk   (clk),
		.wr    (nwr),
		.raddr (n_raddr),
		.rdata (n_rdata)
	);

	wgas_weight_mem u_weights (
		.clk   (clk),
		.wr    (mwr),
		.raddr (m_raddr),
		.rdata (m_rdata)
	);

	// The sequencer runs every request and the matrix clearing pass.
	wgas_seq u_seq (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg),
		.start   (start),
		.req     (req),
		.busy    (busy),
		.done    (done),
		.rsp     (rsp),
		.nwr     (nwr),
		.n_raddr (n_raddr),
		.n_rdata (n_rdata),
		.mwr     (mwr),
		.m_raddr (m_raddr),
		.m_rdata (m_rdata)
	);

endmodule

### design/wgas_name_mem.sv
// Vertex name table: one write port and one registered read port.
`timescale 1ns / 1ps
module wgas_name_mem
	import wgas_pkg::*;
(
	input  logic              clk,
	input  name_wr_t          wr,
	input  logic [IDX_W-1:0]  raddr,
	output logic [NAME_W-1:0] rdata
);

	logic [NAME_W-1:0] mem [MAX_VERTICES];
	logic [NAME_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/wgas_weight_mem.sv
// Weight matrix storage: one write port and one registered read port.
`timescale 1ns / 1ps
module wgas_weight_mem
	import wgas_pkg::*;
(
	input  logic                       clk,
	input  mat_wr_t                    wr,
	input  logic [MAT_AW-1:0]          raddr,
	output logic signed [WEIGHT_W-1:0] rdata
);

	logic signed [WEIGHT_W-1:0] mem [MAT_DEPTH];
	logic signed [WEIGHT_W-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (wr.we) begin
			mem[wr.addr] <= wr.data;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

### design/wgas_seq.sv
// Request sequencer with the shared comparator for name search, edge read and degree scan.
`timescale 1ns / 1ps
module wgas_seq
	import wgas_pkg::*;
(
	input  logic                       clk,
	input  logic                       arst_n,
	input  cfg_t                       cfg,
	input  logic                       start,
	input  req_t                       req,
	output logic                       busy,
	output logic                       done,
	output rsp_t                       rsp,
	output name_wr_t                   nwr,
	output logic [IDX_W-1:0]           n_raddr,
	input  logic [NAME_W-1:0]          n_rdata,
	output mat_wr_t                    mwr,
	output logic [MAT_AW-1:0]          m_raddr,
	input  logic signed [WEIGHT_W-1:0] m_rdata
);

	function automatic logic [MAT_AW-1:0] mat_addr(input logic [IDX_W-1:0] row,
			input logic [IDX_W-1:0] col);
		return MAT_AW'(row) * MAT_AW'(MAX_VERTICES) + MAT_AW'(col);
	endfunction

	state_t              state_q, state_d;
	req_t                req_q;
	logic [VCNT_W-1:0]   scan_q;
	logic                pend_q;
	logic [IDX_W-1:0]    pidx_q;
	logic [IDX_W-1:0]    slot_a_q;
	logic [IDX_W-1:0]    slot_b_q;
	logic [VCNT_W-1:0]   deg_q;
	logic [VCNT_W-1:0]   count_q;
	logic [MAT_AW-1:0]   clr_q;
	logic                done_q;
	rsp_t                rsp_q;

	logic [NAME_W-1:0]   key;
	logic [NAME_W-1:0]   cmp_a, cmp_b;
	logic                cmp_eq;
	logic                hit, exhausted, srch_found, srch_miss, srch_end, deg_fin;
	logic [LIMCMP_W-1:0] limit_ext, lim_eff;
	logic                full, self_loop, null_w;
	logic signed [WEIGHT_W-1:0] wr_val;
	logic                fin;
	rsp_t                rsp_d;

	// Shared comparator: names during a search, weight against null otherwise.
	assign key = ((state_q == S_FIND_B) ? req_q.second_name : req_q.first_name) & NAME_MASK;

	always_comb begin
		if (state_q == S_FIND_A || state_q == S_FIND_B) begin
			cmp_a = n_rdata;
			cmp_b = key;
		end else begin
			cmp_a = {{(NAME_W - WEIGHT_W){1'b0}}, m_rdata};
			cmp_b = {{(NAME_W - WEIGHT_W){1'b0}}, cfg.null_weight};
		end
	end

	assign cmp_eq     = (cmp_a == cmp_b);
	assign hit        = pend_q && cmp_eq;
	assign exhausted  = (scan_q >= count_q);
	assign srch_found = hit;
	assign srch_miss  = !hit && exhausted;
	assign srch_end   = srch_found || srch_miss;
	assign deg_fin    = exhausted && !pend_q;

	assign limit_ext = LIMCMP_W'(cfg.vertex_limit);
	assign lim_eff   = (limit_ext < MAX_LIMIT) ? limit_ext : MAX_LIMIT;
	assign full      = (LIMCMP_W'(count_q) >= lim_eff);
	assign self_loop = (slot_a_q == pidx_q);
	assign null_w    = (req_q.edge_weight == cfg.null_weight);
	assign wr_val    = (req_q.kind == KIND_ADD_EDGE) ? req_q.edge_weight : cfg.null_weight;

	// Next state.
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_CLEAR: begin
				if (clr_q == MAT_AW'(MAT_DEPTH - 1)) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				if (start && !busy) begin
					unique case (req.kind)
						KIND_ADD_VERTEX, KIND_ADD_EDGE, KIND_READ_WEIGHT,
						KIND_DEGREE, KIND_REMOVE_EDGE: state_d = S_FIND_A;
						default:                       state_d = S_IDLE;
					endcase
				end
			end
			S_FIND_A: begin
				if (srch_end) begin
					unique case (req_q.kind)
						KIND_DEGREE: state_d = srch_found ? S_DEGREE : S_IDLE;
						KIND_ADD_EDGE, KIND_READ_WEIGHT, KIND_REMOVE_EDGE:
							state_d = srch_found ? S_FIND_B : S_IDLE;
						default:     state_d = S_IDLE;
					endcase
				end
			end
			S_FIND_B: begin
				if (srch_miss) begin
					state_d = S_IDLE;
				end else if (srch_found) begin
					unique case (req_q.kind)
						KIND_ADD_EDGE:    state_d = (self_loop || null_w) ? S_IDLE : S_WR_AB;
						KIND_REMOVE_EDGE: state_d = S_WR_AB;
						KIND_READ_WEIGHT: state_d = S_RD_ADDR;
						default:          state_d = S_IDLE;
					endcase
				end
			end
			S_WR_AB:   state_d = S_WR_BA;
			S_WR_BA:   state_d = S_IDLE;
			S_RD_ADDR: state_d = S_RD_DATA;
			S_RD_DATA: state_d = S_IDLE;
			S_DEGREE: begin
				if (deg_fin) begin
					state_d = S_IDLE;
				end
			end
			default:   state_d = S_IDLE;
		endcase
		if (cfg.refill) begin
			state_d = S_CLEAR;
		end
	end

	// Outputs: memory ports and the result of the finishing cycle.
	always_comb begin
		nwr     = '0;
		mwr     = '0;
		n_raddr = scan_q[IDX_W-1:0];
		m_raddr = (state_q == S_DEGREE) ? mat_addr(slot_a_q, scan_q[IDX_W-1:0])
		                                : mat_addr(slot_a_q, slot_b_q);
		fin     = 1'b0;
		rsp_d   = '{status: STAT_OK, value: '0};
		unique case (state_q)
			S_CLEAR: begin
				mwr = '{we: 1'b1, addr: clr_q, data: cfg.null_weight};
			end
			S_IDLE: begin
				if (start && !busy) begin
					unique case (req.kind)
						KIND_ADD_VERTEX, KIND_ADD_EDGE, KIND_READ_WEIGHT,
						KIND_DEGREE, KIND_REMOVE_EDGE: fin = 1'b0;
						default:                       fin = 1'b1;
					endcase
				end
			end
			S_FIND_A: begin
				if (srch_end) begin
					unique case (req_q.kind)
						KIND_ADD_VERTEX: begin
							fin = 1'b1;
							if (full) begin
								rsp_d.status = STAT_FULL;
							end else if (srch_found) begin
								rsp_d.status = STAT_DUP;
							end else begin
								nwr = '{we: 1'b1, addr: count_q[IDX_W-1:0],
								        data: req_q.first_name & NAME_MASK};
							end
						end
						default: begin
							if (srch_miss) begin
								fin          = 1'b1;
								rsp_d.status = STAT_NOT_FOUND;
							end
						end
					endcase
				end
			end
			S_FIND_B: begin
				if (srch_miss) begin
					fin          = 1'b1;
					rsp_d.status = STAT_NOT_FOUND;
				end else if (srch_found && req_q.kind == KIND_ADD_EDGE) begin
					if (self_loop) begin
						fin          = 1'b1;
						rsp_d.status = STAT_SELF_LOOP;
					end else if (null_w) begin
						fin          = 1'b1;
						rsp_d.status = STAT_NULL_WEIGHT;
					end
				end
			end
			S_WR_AB: begin
				mwr = '{we: 1'b1, addr: mat_addr(slot_a_q, slot_b_q), data: wr_val};
			end
			S_WR_BA: begin
				mwr = '{we: 1'b1, addr: mat_addr(slot_b_q, slot_a_q), data: wr_val};
				fin = 1'b1;
			end
			S_RD_ADDR: begin
				fin = 1'b0;
			end
			S_RD_DATA: begin
				fin          = 1'b1;
				rsp_d.status = cmp_eq ? STAT_NO_EDGE : STAT_OK;
				rsp_d.value  = m_rdata;
			end
			S_DEGREE: begin
				if (deg_fin) begin
					fin         = 1'b1;
					rsp_d.value = WEIGHT_W'(deg_q);
				end
			end
			default: begin
				fin = 1'b0;
			end
		endcase
	end

	// Control registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q   <= '0;
			scan_q  <= '0;
			pend_q  <= 1'b0;
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= fin;
			if (cfg.refill) begin
				clr_q <= '0;
			end else if (state_q == S_CLEAR) begin
				clr_q <= clr_q + MAT_AW'(1);
			end
			if (nwr.we) begin
				count_q <= count_q + VCNT_W'(1);
			end
			unique case (state_q)
				S_IDLE: begin
					scan_q <= '0;
					pend_q <= 1'b0;
				end
				S_FIND_A, S_FIND_B: begin
					if (srch_end) begin
						scan_q <= '0;
						pend_q <= 1'b0;
					end else begin
						scan_q <= scan_q + VCNT_W'(1);
						pend_q <= 1'b1;
					end
				end
				S_DEGREE: begin
					if (!exhausted) begin
						scan_q <= scan_q + VCNT_W'(1);
						pend_q <= 1'b1;
					end else begin
						pend_q <= 1'b0;
					end
				end
				default: begin
					pend_q <= 1'b0;
				end
			endcase
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && start) begin
			req_q <= req;
		end
		if (fin) begin
			rsp_q <= rsp_d;
		end
		if ((state_q == S_FIND_A || state_q == S_FIND_B) && !srch_end) begin
			pidx_q <= scan_q[IDX_W-1:0];
		end
		if (state_q == S_FIND_A && srch_end) begin
			slot_a_q <= pidx_q;
		end
		if (state_q == S_FIND_B && srch_end) begin
			slot_b_q <= pidx_q;
		end
		if (state_q == S_FIND_A) begin
			deg_q <= '0;
		end else if (state_q == S_DEGREE && pend_q && !cmp_eq) begin
			deg_q <= deg_q + VCNT_W'(1);
		end
	end

	// A pending refill holds requests off until the clearing pass has started.
	assign busy = (state_q != S_IDLE) || cfg.refill;
	assign done = done_q;
	assign rsp  = rsp_q;

`include "weighted_graph_adjacency_store_top_macros.svh"

	`WGAS_ASSERT_HOLD(a_mirror_after_first, clk, arst_n, state_q == S_WR_BA, $past(state_q) == S_WR_AB, "mirror write without its first half")
	`WGAS_ASSERT_HOLD(a_count_steps_by_one, clk, arst_n, count_q != $past(count_q), count_q == $past(count_q) + VCNT_W'(1), "vertex count moved by other than one")
	`WGAS_ASSERT_HOLD(a_name_write_has_room, clk, arst_n, nwr.we, !full, "name written into a full table")
	`WGAS_ASSERT_HOLD(a_degree_bounded, clk, arst_n, state_q == S_DEGREE, deg_q <= scan_q, "degree exceeds entries scanned")
	`WGAS_ASSERT_NEXT(a_read_data_follows, clk, arst_n, state_q == S_RD_ADDR && !cfg.refill, state_q == S_RD_DATA, "edge read lost its data cycle")

endmodule
